// ===== design/tmbe_pkg.sv =====
package tmbe_pkg;

  localparam int unsigned TAPE_CELLS           = 32768;
  localparam int unsigned BRANCH_OPERAND_BYTES = 8;

  localparam int unsigned TAPE_AW = $clog2(TAPE_CELLS);
  localparam int unsigned CELL_W  = 8;
  localparam int unsigned OP_W    = 4;
  localparam int unsigned PSTEP_W = 16;
  localparam int unsigned PC_W    = 16;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned SUM_W   = ((TAPE_AW > PSTEP_W) ? TAPE_AW : PSTEP_W) + 1;

  localparam logic [PC_W-1:0] PC_INC_OP     = PC_W'(1);
  localparam logic [PC_W-1:0] PC_INC_VALUE  = PC_W'(2);
  localparam logic [PC_W-1:0] PC_INC_PTR    = PC_W'(3);
  localparam logic [PC_W-1:0] PC_INC_BRANCH = PC_W'(1 + BRANCH_OPERAND_BYTES);

  localparam logic [SUM_W-1:0]   TAPE_LIMIT = SUM_W'(TAPE_CELLS);
  localparam logic [TAPE_AW-1:0] TAPE_LAST  = TAPE_AW'(TAPE_CELLS - 1);

  typedef enum logic [OP_W-1:0] {
    OP_HALT     = 4'd0,
    OP_PTR_UP   = 4'd1,
    OP_PTR_DOWN = 4'd2,
    OP_ADD      = 4'd3,
    OP_SUB      = 4'd4,
    OP_OUT      = 4'd5,
    OP_IN       = 4'd6,
    OP_JZ       = 4'd7,
    OP_JNZ      = 4'd8,
    OP_DEBUG    = 4'd9
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_BOUNDS  = 3'd1,
    ST_EOF     = 3'd2,
    ST_INVALID = 3'd3,
    ST_HALT    = 3'd4
  } status_e;

  typedef struct packed {
    logic               active;
    logic [TAPE_AW-1:0] addr;
  } clr_t;

endpackage

// ===== design/tmbe_in_if.sv =====
interface tmbe_in_if;
  import tmbe_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [PSTEP_W-1:0] pointer_step;
  logic [CELL_W-1:0]  value_step;
  logic [PC_W-1:0]    jump_target;
  logic [CELL_W-1:0]  input_byte;
  logic               input_at_end;

  modport source (
    output valid, operation, pointer_step, value_step, jump_target, input_byte,
           input_at_end,
    input  ready
  );

  modport sink (
    input  valid, operation, pointer_step, value_step, jump_target, input_byte,
           input_at_end,
    output ready
  );
endinterface

// ===== design/tmbe_out_if.sv =====
interface tmbe_out_if;
  import tmbe_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [PC_W-1:0]   next_pc;
  logic [CELL_W-1:0] out_byte;
  logic              out_valid;

  modport source (
    output valid, status, next_pc, out_byte, out_valid,
    input  ready
  );

  modport sink (
    input  valid, status, next_pc, out_byte, out_valid,
    output ready
  );
endinterface

// ===== design/tmbe_ram.sv =====
module tmbe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== design/tmbe_clear.sv =====
module tmbe_clear (
  input  logic           clk_i,
  input  logic           rst_ni,
  output tmbe_pkg::clr_t clr_o
);
  import tmbe_pkg::*;

  logic               active_q, active_d;
  logic [TAPE_AW-1:0] addr_q, addr_d;

  always_comb begin
    active_d = active_q;
    addr_d   = addr_q;
    if (active_q) begin
      if (addr_q == TAPE_LAST) begin
        active_d = 1'b0;
      end else begin
        addr_d = addr_q + TAPE_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b1;
      addr_q   <= '0;
    end else begin
      active_q <= active_d;
      addr_q   <= addr_d;
    end
  end

  assign clr_o.active = active_q;
  assign clr_o.addr   = addr_q;
endmodule

// ===== design/tape_machine_bytecode_executor.sv =====
// Tape machine bytecode executor.
// in_i carries one decoded instruction per transaction (opcode, pointer and
// value steps, branch target, input byte and end-of-input flag); out_o returns
// one transaction per instruction with status, next program counter and an
// optional output byte. Both channels use valid/ready.
// The byte tape sits in a single-port-read, single-port-write synchronous RAM.
// An instruction reads its cell in the accept cycle and writes the new value
// back as it leaves the execute stage; a write to the cell that the next
// instruction reads is forwarded. A new instruction is accepted every cycle
// while the receiver takes results. After reset all TAPE_CELLS (32768) cells
// are zeroed, one cell per cycle, with in_i.ready low; pointer and program
// counter start at 0. Each result passes the execute stage and the output register.
// When the receiver stalls, the result waits in the output register while one
// more instruction may sit in the execute stage; then in_i.ready drops.
module tape_machine_bytecode_executor (
  input  logic       clk_i,
  input  logic       rst_ni,
  tmbe_in_if.sink    in_i,
  tmbe_out_if.source out_o
);
  import tmbe_pkg::*;

  clr_t clr;

  logic               accept;
  logic               s1_adv;
  logic [TAPE_AW-1:0] dp_q, dp_d;
  logic [PC_W-1:0]    pc_q;
  logic [SUM_W-1:0]   up_sum;
  logic               ptr_err;

  logic               s1_valid_q;
  logic [OP_W-1:0]    s1_op_q;
  logic [CELL_W-1:0]  s1_vstep_q;
  logic [PC_W-1:0]    s1_target_q;
  logic [CELL_W-1:0]  s1_ibyte_q;
  logic               s1_at_end_q;
  logic               s1_ptr_err_q;
  logic [TAPE_AW-1:0] s1_addr_q;
  logic               s1_fwd_hit_q;
  logic [CELL_W-1:0]  s1_fwd_data_q;

  logic [CELL_W-1:0]  ram_rdata;
  logic [CELL_W-1:0]  cell_cur;
  logic [CELL_W-1:0]  cell_new;
  logic               cell_we;
  logic               pipe_we;
  logic               ram_we;
  logic [TAPE_AW-1:0] ram_waddr;
  logic [CELL_W-1:0]  ram_wdata;

  status_e            status_d;
  logic [PC_W-1:0]    next_pc_d;
  logic [CELL_W-1:0]  obyte_d;
  logic               ovalid_d;

  logic               out_valid_q;
  logic [STAT_W-1:0]  out_status_q;
  logic [PC_W-1:0]    out_next_pc_q;
  logic [CELL_W-1:0]  out_byte_q;
  logic               out_ovalid_q;

  tmbe_clear u_clear (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_o  (clr)
  );

  tmbe_ram #(
    .WIDTH (CELL_W),
    .DEPTH (TAPE_CELLS)
  ) u_tape (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (dp_q),
    .rdata_o (ram_rdata)
  );

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !clr.active && (!s1_valid_q || s1_adv);
  assign accept     = in_i.valid && in_i.ready;

  // Issue stage: pointer update and bounds check
  assign up_sum = SUM_W'(dp_q) + SUM_W'(in_i.pointer_step);

  always_comb begin
    ptr_err = 1'b0;
    dp_d    = dp_q;
    case (op_e'(in_i.operation))
      OP_PTR_UP: begin
        if (up_sum >= TAPE_LIMIT) begin
          ptr_err = 1'b1;
        end else begin
          dp_d = up_sum[TAPE_AW-1:0];
        end
      end
      OP_PTR_DOWN: begin
        if (SUM_W'(dp_q) < SUM_W'(in_i.pointer_step)) begin
          ptr_err = 1'b1;
        end else begin
          dp_d = TAPE_AW'(SUM_W'(dp_q) - SUM_W'(in_i.pointer_step));
        end
      end
      default: begin
        ptr_err = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dp_q       <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        dp_q       <= dp_d;
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q       <= in_i.operation;
      s1_vstep_q    <= in_i.value_step;
      s1_target_q   <= in_i.jump_target;
      s1_ibyte_q    <= in_i.input_byte;
      s1_at_end_q   <= in_i.input_at_end;
      s1_ptr_err_q  <= ptr_err;
      s1_addr_q     <= dp_q;
      s1_fwd_hit_q  <= pipe_we && (s1_addr_q == dp_q);
      s1_fwd_data_q <= cell_new;
    end
  end

  // Execute stage: modify cell, resolve branch, next pc
  assign cell_cur = s1_fwd_hit_q ? s1_fwd_data_q : ram_rdata;

  always_comb begin
    status_d  = ST_OK;
    next_pc_d = pc_q + PC_INC_OP;
    obyte_d   = '0;
    ovalid_d  = 1'b0;
    cell_we   = 1'b0;
    cell_new  = cell_cur;
    case (op_e'(s1_op_q))
      OP_HALT: begin
        status_d = ST_HALT;
      end
      OP_PTR_UP, OP_PTR_DOWN: begin
        if (s1_ptr_err_q) begin
          status_d = ST_BOUNDS;
        end else begin
          next_pc_d = pc_q + PC_INC_PTR;
        end
      end
      OP_ADD: begin
        cell_we   = 1'b1;
        cell_new  = cell_cur + s1_vstep_q;
        next_pc_d = pc_q + PC_INC_VALUE;
      end
      OP_SUB: begin
        cell_we   = 1'b1;
        cell_new  = cell_cur - s1_vstep_q;
        next_pc_d = pc_q + PC_INC_VALUE;
      end
      OP_OUT: begin
        obyte_d  = cell_cur;
        ovalid_d = 1'b1;
      end
      OP_IN: begin
        if (s1_at_end_q) begin
          status_d = ST_EOF;
        end else begin
          cell_we  = 1'b1;
          cell_new = s1_ibyte_q;
        end
      end
      OP_JZ: begin
        next_pc_d = (cell_cur == '0) ? s1_target_q : pc_q + PC_INC_BRANCH;
      end
      OP_JNZ: begin
        next_pc_d = (cell_cur != '0) ? s1_target_q : pc_q + PC_INC_BRANCH;
      end
      OP_DEBUG: begin
        status_d = ST_OK;
      end
      default: begin
        status_d = ST_INVALID;
      end
    endcase
  end

  assign pipe_we   = s1_adv && cell_we;
  assign ram_we    = clr.active || pipe_we;
  assign ram_waddr = clr.active ? clr.addr : s1_addr_q;
  assign ram_wdata = clr.active ? '0 : cell_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        pc_q        <= next_pc_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_status_q  <= status_d;
      out_next_pc_q <= next_pc_d;
      out_byte_q    <= obyte_d;
      out_ovalid_q  <= ovalid_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_status_q;
  assign out_o.next_pc   = out_next_pc_q;
  assign out_o.out_byte  = out_byte_q;
  assign out_o.out_valid = out_ovalid_q;

  a_clear_no_pipe_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr.active |-> !pipe_we)
    else $error("pipeline write during tape clear");

  a_clear_no_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr.active |-> (!s1_valid_q && !out_valid_q))
    else $error("instruction in flight during tape clear");

  a_error_pc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && (status_d != ST_OK)) |=> (pc_q == $past(pc_q + PC_INC_OP)))
    else $error("error or halt did not step pc past opcode");

  a_bounds_hold_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ptr_err) |=> (dp_q == $past(dp_q)))
    else $error("pointer moved on out-of-bounds step");

  a_stall_hold_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(pc_q))
    else $error("pc changed without a retired instruction");
endmodule
